/* design/alt_pkg.sv */
package alt_pkg;

    localparam int LINE_MAX  = 4096;
    localparam int MAX_TRAIL = 16;

    localparam int POS_W   = 12;
    localparam int VALUE_W = 31;
    localparam int SYM_W   = 7;
    localparam int TRAIL_W = $clog2(MAX_TRAIL + 2);
    localparam int PROD_W  = VALUE_W + 4;

    localparam logic [POS_W-1:0]   POS_MAX     = POS_W'(LINE_MAX - 1);
    localparam logic [TRAIL_W-1:0] TRAIL_LIMIT = TRAIL_W'(MAX_TRAIL);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_SYMBOL = 3'd2,
        KIND_END    = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_ERROR  = 2'd3
    } lex_mode_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FLUSH = 2'd1,
        PH_TRAIL = 2'd2,
        PH_FIN   = 2'd3
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [SYM_W-1:0]   sym;
        logic [VALUE_W-1:0] value;
        pos_t               start;
        pos_t               len;
    } item_t;

    // results owed for one byte: open token, trailing underscores, own result
    typedef struct packed {
        logic               has_flush;
        item_t              flush_item;
        logic [TRAIL_W-1:0] trail_n;
        pos_t               trail_pos;
        logic               has_fin;
        item_t              fin_item;
    } plan_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic pos_t sat_inc(input pos_t p);
        return (p == POS_MAX) ? p : p + pos_t'(1);
    endfunction

    function automatic item_t make_item(input kind_t kind, input logic [SYM_W-1:0] sym,
                                        input logic [VALUE_W-1:0] value, input pos_t start,
                                        input pos_t len);
        item_t it;
        it.kind  = kind;
        it.sym   = sym;
        it.value = value;
        it.start = start;
        it.len   = len;
        return it;
    endfunction

endpackage

/* design/alt_lexer.sv */
module alt_lexer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      byte_in,
    output alt_pkg::plan_t  plan
);
    import alt_pkg::*;

    lex_mode_t          mode_reg, mode_next;
    pos_t               line_pos_reg, line_pos_next;
    pos_t               token_start_reg, token_start_next;
    pos_t               ident_end_reg, ident_end_next;
    logic [VALUE_W-1:0] accum_reg, accum_next;
    logic [TRAIL_W-1:0] trail_reg, trail_next;

    logic               start_c;
    logic [PROD_W-1:0]  prod;
    pos_t               pos_inc;
    pos_t               one;

    assign pos_inc = sat_inc(line_pos_reg);
    assign one     = pos_t'(1);
    assign prod    = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                   + PROD_W'(byte_in[3:0]);

    always_comb
    begin
        mode_next        = mode_reg;
        line_pos_next    = line_pos_reg;
        token_start_next = token_start_reg;
        ident_end_next   = ident_end_reg;
        accum_next       = accum_reg;
        trail_next       = trail_reg;
        plan             = '0;
        start_c          = 1'b0;

        case (mode_reg)
            MODE_ERROR:
            begin
                if (byte_in == CH_NUL)
                begin
                    mode_next        = MODE_IDLE;
                    line_pos_next    = '0;
                    token_start_next = '0;
                    ident_end_next   = '0;
                    accum_next       = '0;
                    trail_next       = '0;
                end
            end
            MODE_IDENT:
            begin
                if (is_letter(byte_in) || is_digit(byte_in))
                begin
                    trail_next     = '0;
                    ident_end_next = pos_inc;
                    line_pos_next  = pos_inc;
                end
                else if (byte_in == CH_UNDER)
                begin
                    if (trail_reg <= TRAIL_LIMIT)
                        trail_next = trail_reg + TRAIL_W'(1);
                    line_pos_next = pos_inc;
                end
                else
                begin
                    plan.has_flush  = 1'b1;
                    plan.flush_item = make_item(KIND_IDENT, '0, '0, token_start_reg,
                                                ident_end_reg - token_start_reg);
                    mode_next = MODE_IDLE;
                    if (trail_reg > TRAIL_LIMIT)
                    begin
                        plan.has_fin  = 1'b1;
                        plan.fin_item = make_item(KIND_ERROR, '0, '0, ident_end_reg, '0);
                        if (byte_in == CH_NUL)
                        begin
                            line_pos_next    = '0;
                            token_start_next = '0;
                            ident_end_next   = '0;
                            accum_next       = '0;
                            trail_next       = '0;
                        end
                        else
                            mode_next = MODE_ERROR;
                    end
                    else
                    begin
                        plan.trail_n   = trail_reg;
                        plan.trail_pos = ident_end_reg;
                        start_c        = 1'b1;
                    end
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(byte_in))
                begin
                    if (prod[PROD_W-1:VALUE_W] != '0)
                    begin
                        plan.has_fin  = 1'b1;
                        plan.fin_item = make_item(KIND_ERROR, '0, '0, pos_inc, '0);
                        mode_next     = MODE_ERROR;
                    end
                    else
                        accum_next = prod[VALUE_W-1:0];
                    line_pos_next = pos_inc;
                end
                else
                begin
                    plan.has_flush  = 1'b1;
                    plan.flush_item = make_item(KIND_NUMBER, '0, accum_reg, token_start_reg,
                                                '0);
                    mode_next  = MODE_IDLE;
                    accum_next = '0;
                    start_c    = 1'b1;
                end
            end
            default:
                start_c = 1'b1;
        endcase

        if (start_c)
        begin
            line_pos_next = pos_inc;
            if (byte_in == CH_NUL)
            begin
                plan.has_fin     = 1'b1;
                plan.fin_item    = make_item(KIND_END, '0, '0, line_pos_reg, '0);
                mode_next        = MODE_IDLE;
                line_pos_next    = '0;
                token_start_next = '0;
                ident_end_next   = '0;
                accum_next       = '0;
                trail_next       = '0;
            end
            else if (is_letter(byte_in))
            begin
                mode_next        = MODE_IDENT;
                token_start_next = line_pos_reg;
                ident_end_next   = pos_inc;
                trail_next       = '0;
            end
            else if (is_digit(byte_in))
            begin
                mode_next        = MODE_NUMBER;
                token_start_next = line_pos_reg;
                accum_next       = VALUE_W'(byte_in[3:0]);
            end
            else if (is_space(byte_in))
            begin
                mode_next = mode_next;
            end
            else if (byte_in >= CH_BANG && byte_in <= CH_TILDE)
            begin
                plan.has_fin  = 1'b1;
                plan.fin_item = make_item(KIND_SYMBOL, byte_in[SYM_W-1:0], '0,
                                          line_pos_reg, one);
            end
            else
            begin
                plan.has_fin  = 1'b1;
                plan.fin_item = make_item(KIND_ERROR, '0, '0, line_pos_reg, '0);
                mode_next     = MODE_ERROR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            line_pos_reg    <= '0;
            token_start_reg <= '0;
            ident_end_reg   <= '0;
            accum_reg       <= '0;
            trail_reg       <= '0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            line_pos_reg    <= line_pos_next;
            token_start_reg <= token_start_next;
            ident_end_reg   <= ident_end_next;
            accum_reg       <= accum_next;
            trail_reg       <= trail_next;
        end
    end

endmodule

/* design/alt_emit.sv */
module alt_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load_req,
    input  alt_pkg::plan_t  plan_in,
    output logic            load_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output alt_pkg::item_t  out_item,
    output logic            out_last
);
    import alt_pkg::*;

    phase_t phase_reg, phase_next;
    phase_t after;
    phase_t first;
    plan_t  plan_reg, plan_next;
    item_t  cur;
    logic   emit;
    logic   load;
    logic   out_valid_reg, out_valid_next;
    item_t  out_item_reg, out_item_next;
    logic   out_last_reg, out_last_next;

    always_comb
    begin
        case (phase_reg)
            PH_FLUSH:
            begin
                cur = plan_reg.flush_item;
                if (plan_reg.trail_n != '0)
                    after = PH_TRAIL;
                else if (plan_reg.has_fin)
                    after = PH_FIN;
                else
                    after = PH_IDLE;
            end
            PH_TRAIL:
            begin
                cur = make_item(KIND_SYMBOL, CH_UNDER[SYM_W-1:0], '0, plan_reg.trail_pos,
                                pos_t'(1));
                if (plan_reg.trail_n != TRAIL_W'(1))
                    after = PH_TRAIL;
                else if (plan_reg.has_fin)
                    after = PH_FIN;
                else
                    after = PH_IDLE;
            end
            PH_FIN:
            begin
                cur   = plan_reg.fin_item;
                after = PH_IDLE;
            end
            default:
            begin
                cur   = plan_reg.fin_item;
                after = PH_IDLE;
            end
        endcase

        if (plan_in.has_flush)
            first = PH_FLUSH;
        else if (plan_in.has_fin)
            first = PH_FIN;
        else
            first = PH_IDLE;

        emit    = (phase_reg != PH_IDLE) && (!out_valid_reg || out_ready);
        load_ok = (phase_reg == PH_IDLE) || (emit && after == PH_IDLE);
        load    = load_req && load_ok;

        phase_next = phase_reg;
        plan_next  = plan_reg;
        if (emit)
        begin
            phase_next = after;
            if (phase_reg == PH_TRAIL)
            begin
                plan_next.trail_n   = plan_reg.trail_n - TRAIL_W'(1);
                plan_next.trail_pos = sat_inc(plan_reg.trail_pos);
            end
        end
        if (load)
        begin
            phase_next = first;
            plan_next  = plan_in;
        end

        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_item_next  = cur;
            out_last_next  = (after == PH_IDLE);
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg     <= plan_next;
        out_item_reg <= out_item_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_last  = out_last_reg;

endmodule

/* design/ascii_line_tokenizer.sv */
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: byte_in
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata, tuser, tlast: one token per word
//
// A byte is taken every cycle while its results can be queued; each result word
// goes through the plan and output registers, one per cycle unless m_axis stalls.
// A byte owing several results holds the input until its last word is being sent;
// the sequencer steps out its trailing underscore tokens one by one.
// rst_n is asynchronous; after it the line position is zero and no token is open.
// A stalled output holds its word; input is refused only while owed words queue.
module ascii_line_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [6:0] symbol_char, [37:7] number_value,
                                        // [49:38] start_pos, [61:50] token_len, rest 0
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    output logic        m_axis_tlast    // last_result
);
    import alt_pkg::*;

    plan_t plan;
    item_t item;
    logic  load_ok;
    logic  accept;

    assign accept        = s_axis_tvalid && load_ok;
    assign s_axis_tready = load_ok;

    alt_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (s_axis_tdata),
        .plan    (plan)
    );

    alt_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_req  (accept),
        .plan_in   (plan),
        .load_ok   (load_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (item),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, item.len, item.start, item.value, item.sym};
    assign m_axis_tuser = item.kind;

endmodule
